[hw/rtl/framed_command_receiver_top_macros.svh]
// Assertion macros for the framed command receiver.
// Used by the RTL files that carry concurrent checks; expects clock and reset in scope.
`ifndef FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FCR_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/fcr_pkg.sv]
// Shared types and constants of the framed command receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package fcr_pkg;

   // Frame format
   localparam int unsigned HEADER_BYTES = 3;
   localparam int unsigned FIELD_DEPTH  = 12;
   localparam int unsigned FCR_QUEUE_DEPTH = 4;

   localparam logic [7:0] START_FIRST  = 8'hDE;
   localparam logic [7:0] START_SECOND = 8'hAD;

   // Command codes
   localparam logic [7:0] CMD_READ   = 8'h72;
   localparam logic [7:0] CMD_TITLE  = 8'h6C;
   localparam logic [7:0] CMD_BACKUP = 8'hBE;

   // Event kinds
   localparam logic [2:0] EVT_PAYLOAD     = 3'd0;
   localparam logic [2:0] EVT_SECTOR_READ = 3'd1;
   localparam logic [2:0] EVT_LOAD_TITLE  = 3'd2;
   localparam logic [2:0] EVT_BACKUP      = 3'd3;
   localparam logic [2:0] EVT_UNKNOWN     = 3'd4;

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_HEADER,
      ST_PAYLOAD
   } fcr_state_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]  event_kind;
      logic [15:0] payload_index;
      logic [7:0]  payload_value;
      logic [7:0]  command_code;
      logic [15:0] frame_length;
      logic [31:0] sector_high;
      logic [31:0] sector_low;
      logic [31:0] sector_count;
      logic        last_of_run;
   } fcr_result_type;

   // Results of one byte, pushed into the queue together
   typedef struct packed {
      logic [1:0]     count;
      fcr_result_type first;
      fcr_result_type second;
   } fcr_push_type;

endpackage

`default_nettype wire

[hw/rtl/fcr_parser.sv]
// Frame parser: hunt/header/payload state, header and field byte stores.
// Depends on fcr_pkg and the assertion macro header.
`default_nettype none
`include "framed_command_receiver_top_macros.svh"

module fcr_parser
   import fcr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire logic [7:0]   rx_byte,
   output fcr_push_type      push
);

   localparam logic [1:0] HEADER_LAST = 2'(HEADER_BYTES - 1);

   fcr_state_type state_ff, state_in;
   logic          armed_ff, armed_in;
   logic [1:0]    hdr_pos_ff, hdr_pos_in;
   logic [7:0]    hdr_bytes_ff [HEADER_BYTES];
   logic [7:0]    hdr_bytes_in [HEADER_BYTES];
   logic [15:0]   pay_pos_ff, pay_pos_in;
   logic [15:0]   pay_len_ff, pay_len_in;
   logic [7:0]    field_ff [FIELD_DEPTH];
   logic [7:0]    field_in [FIELD_DEPTH];

   logic          header_done;
   logic [15:0]   hdr_len;
   logic [15:0]   pay_pos_inc;
   logic          pay_done;
   logic          finish;
   logic [7:0]    cmd;
   logic [2:0]    finish_kind;
   fcr_result_type pay_res;
   fcr_result_type fin_res;

   // Store updates for the current byte
   always_comb begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
         hdr_bytes_in[i] = hdr_bytes_ff[i];
         if (state_ff == ST_HEADER && hdr_pos_ff == 2'(i)) begin
            hdr_bytes_in[i] = rx_byte;
         end
      end
      for (int i = 0; i < FIELD_DEPTH; i++) begin
         field_in[i] = field_ff[i];
         if (state_ff == ST_PAYLOAD && pay_pos_ff == 16'(i)) begin
            field_in[i] = rx_byte;
         end
      end
   end

   assign header_done = (state_ff == ST_HEADER) && (hdr_pos_ff == HEADER_LAST);
   assign hdr_len     = {hdr_bytes_ff[1], rx_byte};
   assign pay_pos_inc = pay_pos_ff + 16'd1;
   assign pay_done    = (state_ff == ST_PAYLOAD) && (pay_pos_inc >= pay_len_ff);
   assign finish      = pay_done || (header_done && hdr_len == 16'd0);
   assign cmd         = hdr_bytes_in[0];

   // Next state
   always_comb begin
      state_in   = state_ff;
      armed_in   = armed_ff;
      hdr_pos_in = hdr_pos_ff;
      pay_pos_in = pay_pos_ff;
      pay_len_in = pay_len_ff;
      case (state_ff)
         ST_HUNT: begin
            if (rx_byte == START_FIRST) begin
               armed_in = 1'b1;
            end else if (rx_byte == START_SECOND && armed_ff) begin
               state_in   = ST_HEADER;
               hdr_pos_in = 2'd0;
            end
         end
         ST_HEADER: begin
            hdr_pos_in = hdr_pos_ff + 2'd1;
            if (header_done) begin
               hdr_pos_in = 2'd0;
               pay_pos_in = 16'd0;
               pay_len_in = hdr_len;
               state_in   = (hdr_len == 16'd0) ? ST_HUNT : ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            pay_pos_in = pay_pos_inc;
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
      // Frame end drops the arming and the length
      if (finish) begin
         state_in   = ST_HUNT;
         armed_in   = 1'b0;
         pay_pos_in = 16'd0;
         pay_len_in = 16'd0;
      end
   end

   // Result contents
   always_comb begin
      case (cmd)
         CMD_READ:   finish_kind = EVT_SECTOR_READ;
         CMD_TITLE:  finish_kind = EVT_LOAD_TITLE;
         CMD_BACKUP: finish_kind = EVT_BACKUP;
         default:    finish_kind = EVT_UNKNOWN;
      endcase

      pay_res               = '0;
      pay_res.event_kind    = EVT_PAYLOAD;
      pay_res.payload_index = pay_pos_ff;
      pay_res.payload_value = rx_byte;
      pay_res.command_code  = cmd;
      pay_res.frame_length  = pay_len_ff;
      pay_res.last_of_run   = !pay_done;

      fin_res              = '0;
      fin_res.event_kind   = finish_kind;
      fin_res.command_code = cmd;
      fin_res.frame_length = (state_ff == ST_PAYLOAD) ? pay_len_ff : hdr_len;
      fin_res.last_of_run  = 1'b1;
      if (finish_kind == EVT_SECTOR_READ) begin
         fin_res.sector_high  = {field_in[0], field_in[1], field_in[2], field_in[3]};
         fin_res.sector_low   = {field_in[4], field_in[5], field_in[6], field_in[7]};
         fin_res.sector_count = {field_in[8], field_in[9], field_in[10], field_in[11]};
      end

      push        = '0;
      push.first  = (state_ff == ST_PAYLOAD) ? pay_res : fin_res;
      push.second = fin_res;
      if (take) begin
         if (state_ff == ST_PAYLOAD) begin
            push.count = pay_done ? 2'd2 : 2'd1;
         end else if (finish) begin
            push.count = 2'd1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HUNT;
         armed_ff   <= 1'b0;
         hdr_pos_ff <= 2'd0;
         pay_pos_ff <= 16'd0;
         pay_len_ff <= 16'd0;
         for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr_bytes_ff[i] <= 8'd0;
         end
      end else if (take) begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         hdr_pos_ff   <= hdr_pos_in;
         pay_pos_ff   <= pay_pos_in;
         pay_len_ff   <= pay_len_in;
         hdr_bytes_ff <= hdr_bytes_in;
      end
   end

   // First payload bytes of the frame, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         field_ff <= field_in;
      end
   end

   `FCR_ASSERT_HOLDS(a_pos_below_len, state_ff == ST_PAYLOAD, pay_pos_ff < pay_len_ff, "payload position past length")
   `FCR_ASSERT_HOLDS(a_two_from_payload, push.count == 2'd2, take && state_ff == ST_PAYLOAD, "two results outside payload")
   `FCR_ASSERT_NEXT(a_finish_clears, take && finish, !armed_ff && state_ff == ST_HUNT && pay_len_ff == 16'd0, "frame end did not clear state")
   `FCR_ASSERT_HOLDS(a_hdr_pos_idle, state_ff != ST_HEADER, hdr_pos_ff == 2'd0, "header position left over")

endmodule

`default_nettype wire

[hw/rtl/fcr_result_queue.sv]
// Result queue: takes up to two results per cycle while it has room, hands out one per cycle unless stalled.
// Depends on fcr_pkg and the assertion macro header.
`default_nettype none
`include "framed_command_receiver_top_macros.svh"

module fcr_result_queue
   import fcr_pkg::*;
#(
   parameter int unsigned DEPTH = FCR_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fcr_push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output fcr_result_type    head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   fcr_result_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_one;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop        = rsp_valid && !rsp_stall;
   assign rsp_valid  = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign room       = (count_ff <= CNT_W'(DEPTH - 2));
   assign wr_ptr_one = ptr_inc(wr_ptr_ff);

   // Pointer and fill level updates
   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_one;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_one);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry writes, two lanes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_one] <= push.second;
      end
   end

   `FCR_ASSERT_HOLDS(a_push_with_room, push.count != 2'd0, room, "result pushed without room")

endmodule

`default_nettype wire

[hw/rtl/framed_command_receiver_top.sv]
// Framed command receiver top level: input register, parser and result queue.
// Depends on fcr_pkg, fcr_parser and fcr_result_queue.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_stall    req_rx_byte
//   rsp_      out        rsp_valid/rsp_stall    event kind, index, value, command,
//                                               length, sector words, last_of_run
//
// One byte per cycle while req_stall is low; an accepted byte is held in the input register,
// passes the parser and is written into the result queue once it has room; rsp_ shows the queue head.
// The result queue drains one transaction per cycle while rsp_stall is low, so a byte that
// ends a payload yields two results, handed out one after the other.
// req_stall rises while the input register is full and the queue has fewer than
// two free entries; it comes from registers only.
// Synchronous reset clears control state; the field byte store is not cleared.
`default_nettype none

module framed_command_receiver_top
   import fcr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = FCR_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_event_kind,
   output logic [15:0]       rsp_payload_index,
   output logic [7:0]        rsp_payload_value,
   output logic [7:0]        rsp_command_code,
   output logic [15:0]       rsp_frame_length,
   output logic [31:0]       rsp_sector_high,
   output logic [31:0]       rsp_sector_low,
   output logic [31:0]       rsp_sector_count,
   output logic              rsp_last_of_run
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           room;
   logic           take;
   fcr_push_type   push;
   fcr_result_type head;

   // Input register
   assign take      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_byte_in = req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   fcr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (in_byte_ff),
      .push    (push)
   );

   fcr_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   // Result fields
   assign rsp_event_kind    = head.event_kind;
   assign rsp_payload_index = head.payload_index;
   assign rsp_payload_value = head.payload_value;
   assign rsp_command_code  = head.command_code;
   assign rsp_frame_length  = head.frame_length;
   assign rsp_sector_high   = head.sector_high;
   assign rsp_sector_low    = head.sector_low;
   assign rsp_sector_count  = head.sector_count;
   assign rsp_last_of_run   = head.last_of_run;

endmodule

`default_nettype wire
